FILE: sv/lsrc_pkg.sv
// Shared constants for the Lagrange sample rate converter.
// No dependencies; used by lsrc_front, lsrc_queue, lsrc_back and the top level.
package lsrc_pkg;

    // Number of taps in the history ring (5-point interpolation)
    localparam int RING_LEN = 5;

    // Depth of the job queue between the front and back parts
    localparam int JOB_DEPTH = 4;

    // Node index j used by lane k at multiply step s (skips j == k)
    function automatic int lane_node(input int k, input int s);
        return (s < k) ? s : s + 1;
    endfunction

endpackage

FILE: sv/lsrc_queue.sv
// Small register FIFO carrying interpolation jobs from front to back.
// Depends on lsrc_pkg for its depth.
module lsrc_queue #(
    parameter int WIDTH = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(lsrc_pkg::JOB_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_mem [lsrc_pkg::JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(lsrc_pkg::JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store a request at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr && !o_full, i_rd && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/lsrc_front.sv
// Front part: accepts samples, keeps the history ring and the position,
// and issues one interpolation job per output. Depends on lsrc_pkg.
module lsrc_front #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16,
    parameter int MAX_OUTPUTS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [FRACTION_BITS+6:0]        i_cfg_wdata,
    input  logic                            i_take,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_job_full,
    output logic                            o_job_push,
    output logic [FRACTION_BITS:0]          o_job,
    output logic                            o_idle,
    output logic signed [SAMPLE_BITS-1:0]   o_hist [lsrc_pkg::RING_LEN]
);

    localparam int PB    = FRACTION_BITS + 8;
    localparam int RB    = FRACTION_BITS + 7;
    localparam int CW    = $clog2(MAX_OUTPUTS + 1);
    localparam logic [PB-1:0] ONE = PB'(1) << FRACTION_BITS;
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_OUTPUTS);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_OUTPUTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_GEN  = 1'b1;

    logic                          r_state;
    logic [PB-1:0]                 r_pos;
    logic [CW-1:0]                 r_cnt;
    logic [RB-1:0]                 r_ratio;
    logic signed [SAMPLE_BITS-1:0] r_hist [lsrc_pkg::RING_LEN];
    logic [PB-1:0]                 pos_sum;
    logic                          more;
    logic                          last;

    assign o_idle = (r_state == ST_IDLE);
    assign o_hist = r_hist;

    // Position after this output and whether another one follows
    assign pos_sum    = r_pos + PB'(r_ratio);
    assign more       = (r_pos < ONE) && (r_cnt < CNT_MAX);
    assign last       = (pos_sum >= ONE) || (r_cnt == CNT_LAST);
    assign o_job_push = (r_state == ST_GEN) && more && !i_job_full;
    assign o_job      = {last, r_pos[FRACTION_BITS-1:0]};

    // Shift the new sample in, oldest at index zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lsrc_pkg::RING_LEN; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_take) begin
            for (int i = 0; i < lsrc_pkg::RING_LEN - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[lsrc_pkg::RING_LEN-1] <= i_sample;
        end
    end

    // Hold the rate ratio
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RB'(ONE);
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_wdata;
        end
    end

    // Step the position and issue jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= ONE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_take) begin
                        r_pos   <= (r_pos >= ONE) ? r_pos - ONE : '0;
                        r_cnt   <= '0;
                        r_state <= ST_GEN;
                    end
                end
                ST_GEN: begin
                    if (!more) begin
                        r_state <= ST_IDLE;
                    end else if (!i_job_full) begin
                        r_pos <= pos_sum;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/lsrc_back.sv
// Back part: evaluates the five Lagrange weights in parallel lanes, one
// multiply per lane per cycle, then sums, scales and saturates. Depends on lsrc_pkg.
module lsrc_back #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_empty,
    input  logic [FRACTION_BITS:0]          i_job,
    output logic                            o_job_pop,
    input  logic signed [SAMPLE_BITS-1:0]   i_hist [lsrc_pkg::RING_LEN],
    output logic                            o_busy,
    input  logic                            i_pop,
    output logic                            o_empty,
    output logic signed [SAMPLE_BITS-1:0]   o_value,
    output logic                            o_last
);

    localparam int SB  = SAMPLE_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int DW  = FB + 3;
    localparam int PW  = FB + 6;
    localparam int MW  = PW + DW;
    localparam int XW  = SB + PW;
    localparam int AW  = XW + 4;
    localparam int YW  = AW - (FB + 3);
    localparam int BW  = SB + 2;
    localparam int KSH = SB + 4;
    localparam int RW  = KSH - 1;
    localparam int NL  = lsrc_pkg::RING_LEN;

    localparam logic signed [MW-1:0] HALF = MW'(longint'(1) << (FB - 1));
    localparam logic signed [AW-1:0] BIAS = AW'(longint'(12) << FB);
    localparam logic signed [YW-1:0] Y_LO = YW'(-(longint'(3) << (SB - 1)));
    localparam logic signed [YW-1:0] Y_HI = YW'((longint'(3) << (SB - 1)) - 1);
    localparam logic [RW-1:0]        RECIP = RW'(((longint'(1) << KSH) / 3) + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_PROD  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_RECIP = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]             r_state;
    logic [1:0]             r_step;
    logic [FB-1:0]          r_u;
    logic                   r_job_last;
    logic signed [PW-1:0]   r_p    [NL];
    logic signed [XW-1:0]   r_prod [NL];
    logic signed [AW-1:0]   r_acc;
    logic [BW-1:0]          r_yb;
    logic [SB-1:0]          r_q;
    logic                   r_ovalid;
    logic signed [SB-1:0]   r_value;
    logic                   r_last;

    logic signed [DW-1:0]   d [NL];
    logic signed [AW-1:0]   acc_sum;
    logic signed [YW-1:0]   y;
    logic signed [YW-1:0]   y_clamp;
    logic [BW+RW-1:0]       q_full;
    logic                   out_free;

    assign o_busy    = (r_state != ST_IDLE);
    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;
    assign o_empty   = !r_ovalid;
    assign o_value   = r_value;
    assign o_last    = r_last;
    assign out_free  = !r_ovalid || i_pop;

    // Node terms d_j = (j-2)*one - u
    always_comb begin
        for (int j = 0; j < NL; j++) begin
            d[j] = DW'(longint'(j - 2) <<< FB) - DW'({1'b0, r_u});
        end
    end

    // One lane per tap: build the weight product, then scale the sample
    for (genvar k = 0; k < NL; k++) begin : g_lane
        logic signed [DW-1:0] d_sel;
        logic signed [MW-1:0] mul;

        always_comb begin
            case (r_step)
                2'd0:    d_sel = d[lsrc_pkg::lane_node(k, 0)];
                2'd1:    d_sel = d[lsrc_pkg::lane_node(k, 1)];
                2'd2:    d_sel = d[lsrc_pkg::lane_node(k, 2)];
                default: d_sel = d[lsrc_pkg::lane_node(k, 3)];
            endcase
        end

        assign mul = MW'(r_p[k]) * MW'(d_sel);

        always_ff @(posedge i_clk) begin
            if (r_state == ST_MUL) begin
                if (r_step == 2'd0) begin
                    r_p[k] <= PW'(d_sel);
                end else begin
                    r_p[k] <= PW'((mul + HALF) >>> FB);
                end
            end
            if (r_state == ST_PROD) begin
                r_prod[k] <= XW'(i_hist[k]) * XW'(r_p[k]);
            end
        end
    end

    // Weighted sum with weights 1, -4, 6, -4, 1
    always_comb begin
        acc_sum = AW'(r_prod[0]) + AW'(r_prod[4])
                - (AW'(r_prod[1]) <<< 2) - (AW'(r_prod[3]) <<< 2)
                + (AW'(r_prod[2]) <<< 2) + (AW'(r_prod[2]) <<< 1);
    end

    // Divide by 8*one with floor, clamp to the range that maps into the output
    assign y       = YW'((r_acc + BIAS) >>> (FB + 3));
    assign y_clamp = (y < Y_LO) ? Y_LO : ((y > Y_HI) ? Y_HI : y);
    assign q_full  = (BW + RW)'(r_yb) * (BW + RW)'(RECIP);

    // Datapath registers along the sequence
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_u        <= i_job[FB-1:0];
            r_job_last <= i_job[FB];
        end
        if (r_state == ST_SUM) begin
            r_acc <= acc_sum;
        end
        if (r_state == ST_SCALE) begin
            r_yb <= BW'(y_clamp - Y_LO);
        end
        if (r_state == ST_RECIP) begin
            r_q <= q_full[KSH +: SB];
        end
        if (r_state == ST_OUT && out_free) begin
            r_value <= {~r_q[SB-1], r_q[SB-2:0]};
            r_last  <= r_job_last;
        end
    end

    // Sequence one output and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_step  <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD:  r_state <= ST_SUM;
                ST_SUM:   r_state <= ST_SCALE;
                ST_SCALE: r_state <= ST_RECIP;
                ST_RECIP: r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/lagrange_sample_rate_converter.sv
// 5-point Lagrange resampler. Each output passes through the back part in steps
// (four per-lane multiply steps, product, sum, scale, reciprocal divide,
// output load); the next sample is taken once all jobs of the current one
// have left the back.
// Synchronous active-low reset: ring zero, position one, ratio one, job queue and output register empty.
module lagrange_sample_rate_converter #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16,
    parameter int MAX_OUTPUTS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [FRACTION_BITS+6:0]      i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_last
);

    localparam int JW = FRACTION_BITS + 1;

    logic                          take;
    logic                          front_idle;
    logic                          back_busy;
    logic                          job_push, job_pop, job_full, job_empty;
    logic [JW-1:0]                 job_in, job_out;
    logic signed [SAMPLE_BITS-1:0] hist [lsrc_pkg::RING_LEN];

    // Take a sample only when all earlier work has cleared the ring readers
    assign full = !front_idle || !job_empty || back_busy;
    assign take = push && !full;

    lsrc_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_OUTPUTS   (MAX_OUTPUTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_sample    (i_sample),
        .i_job_full  (job_full),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .o_idle      (front_idle),
        .o_hist      (hist)
    );

    lsrc_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_data  (job_in),
        .i_rd    (job_pop),
        .o_data  (job_out),
        .o_full  (job_full),
        .o_empty (job_empty)
    );

    lsrc_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_hist      (hist),
        .o_busy      (back_busy),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule
